// File: hdl/zrkmc_pkg.sv
// ----------------------------------------------------------------------------
// zrkmc_pkg
// Shared types and constants for the zero-range kinetic Monte Carlo event
// step: transaction structs, command and outcome codes, cell control group.
// ----------------------------------------------------------------------------
package zrkmc_pkg;

  localparam int NUM_BINS_DEF = 64;
  localparam int IDX_W_DEF    = $clog2(NUM_BINS_DEF);

  localparam int CMD_W    = 2;
  localparam int BIN_W    = 6;
  localparam int OCC_W    = 16;
  localparam int RATE_W   = 32;
  localparam int SQ_W     = 2 * OCC_W;
  localparam int TOTAL_W  = 38;
  localparam int OUTC_W   = 3;

  localparam logic [OCC_W-1:0] OCC_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVENT = 2'd2;

  localparam logic [OUTC_W-1:0] OUT_NONE   = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_HOP    = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_EXIT_L = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_EXIT_R = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_INJ_L  = 3'd4;
  localparam logic [OUTC_W-1:0] OUT_INJ_R  = 3'd5;
  localparam logic [OUTC_W-1:0] OUT_REJECT = 3'd6;
  localparam logic [OUTC_W-1:0] OUT_ZERO   = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BIN_W-1:0]  bin;
    logic [OCC_W-1:0]  value;
    logic [RATE_W-1:0] rand_rate;
    logic              rand_dir;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_rate;
    logic [BIN_W-1:0]   chosen_bin;
    logic               went_right;
    logic [OUTC_W-1:0]  outcome;
    logic [OCC_W-1:0]   read_value;
  } res_item_t;

  typedef struct packed {
    logic             shift;
    logic             load;
    logic             dec;
    logic             inc;
    logic [OCC_W-1:0] load_val;
  } cell_ctl_t;

  typedef struct packed {
    logic [OCC_W-1:0] left;
    logic [OCC_W-1:0] cur;
    logic [OCC_W-1:0] right;
  } hop_vals_t;

endpackage

// File: hdl/zrkmc_cell.sv
// ----------------------------------------------------------------------------
// zrkmc_cell
// One bin of the occupancy ring: shifts to its neighbour during a scan,
// otherwise loads, decrements or increments (saturating) when addressed.
// ----------------------------------------------------------------------------
module zrkmc_cell import zrkmc_pkg::*; #(
  parameter int IDX_W = IDX_W_DEF,
  parameter int POS   = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] load_idx,
  input  logic [IDX_W-1:0] dec_idx,
  input  logic [IDX_W-1:0] inc_idx,
  input  logic [OCC_W-1:0] nbr,
  output logic [OCC_W-1:0] occ
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);

  logic hit_load, hit_dec, hit_inc;

  assign hit_load = ctl.load && (load_idx == MY_IDX);
  assign hit_dec  = ctl.dec  && (dec_idx  == MY_IDX) && (occ != '0);
  assign hit_inc  = ctl.inc  && (inc_idx  == MY_IDX) && (occ != OCC_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (ctl.shift) begin
      occ <= nbr;
    end else if (hit_load) begin
      occ <= ctl.load_val;
    end else if (hit_dec) begin
      occ <= occ - OCC_W'(1);
    end else if (hit_inc) begin
      occ <= occ + OCC_W'(1);
    end
  end

endmodule

// File: hdl/zrkmc_scan.sv
// ----------------------------------------------------------------------------
// zrkmc_scan
// Selection pipeline at the ring head: square each passing occupancy,
// accumulate, and mark the first bin whose cumulative rate reaches the
// threshold, keeping the occupancies of it and its two neighbours.
// ----------------------------------------------------------------------------
module zrkmc_scan import zrkmc_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF,
  parameter int IDX_W    = $clog2(NUM_BINS),
  parameter int SUM_W    = SQ_W + $clog2(NUM_BINS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             tap_valid,
  input  logic [OCC_W-1:0] tap_val,
  input  logic [IDX_W-1:0] tap_idx,
  input  logic [SUM_W-1:0] thresh,
  input  logic             rem,
  output logic [IDX_W-1:0] sel,
  output hop_vals_t        vals
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BINS - 1);

  logic             val1, val2, found, just_found;
  logic [OCC_W-1:0] v1, v2, prev_v;
  logic [IDX_W-1:0] i1, i2;
  logic [SQ_W-1:0]  sq2;
  logic [SUM_W-1:0] cum, cum_next;
  logic             not_below, hit;

  assign cum_next  = cum + SUM_W'(sq2);
  assign not_below = (cum_next > thresh) || ((cum_next == thresh) && !rem);
  assign hit       = val2 && !found && not_below;

  always_ff @(posedge clk) begin
    if (rst) begin
      val1       <= 1'b0;
      val2       <= 1'b0;
      found      <= 1'b0;
      just_found <= 1'b0;
    end else begin
      val1 <= tap_valid;
      val2 <= val1;
      if (clear) begin
        found      <= 1'b0;
        just_found <= 1'b0;
      end else begin
        just_found <= hit;
        if (hit) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    v1  <= tap_val;
    i1  <= tap_idx;
    v2  <= v1;
    i2  <= i1;
    sq2 <= SQ_W'(v1) * SQ_W'(v1);
    if (clear) begin
      cum <= '0;
      sel <= IDX_LAST;
    end else if (val2) begin
      cum    <= cum_next;
      prev_v <= v2;
      if (hit) begin
        sel       <= i2;
        vals.cur  <= v2;
        vals.left <= prev_v;
      end
      if (just_found) begin
        vals.right <= v2;
      end
    end
  end

endmodule

// File: hdl/zero_range_kmc_event_step_top.sv
// ----------------------------------------------------------------------------
// zero_range_kmc_event_step_top
// Zero-range process event step with reservoir end bins: write, read or one
// kinetic Monte Carlo event over a ring of occupancy cells.
//
//   channel   signals               direction   handshake
//   command   start, busy, item     in          taken when start && !busy
//   result    done, result          out         one cycle per strobe, no stall
//
// Event: two multiply steps, one lap of the ring through the head squarer,
//   the drain states S_FILL and S_FLUSH, then the hop state. Read: one lap
//   of the ring. Write: one lap of the ring, a squaring step, a write step.
// Unused command, or an event while the total rate is zero: never busy.
// The result strobe follows the last busy cycle; the next command may be
//   taken in that same cycle. Reset clears all bins and the total rate.
// ----------------------------------------------------------------------------
module zero_range_kmc_event_step_top import zrkmc_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      done,
  output res_item_t result
);

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int SUM_W = SQ_W + IDX_W;
  localparam int HI_W  = SUM_W - RATE_W;
  localparam int HP_W  = HI_W + RATE_W;
  localparam int P_W   = SUM_W + RATE_W;
  localparam int LO_W  = 2 * RATE_W;

  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_BINS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST2 = IDX_W'(NUM_BINS - 2);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PROD, S_SCAN, S_FILL, S_FLUSH, S_HOP, S_SQ, S_WRITE
  } state_t;

  state_t           state;
  in_item_t         req;
  logic [SUM_W-1:0] total, thresh, total_hop, total_wr;
  logic             rem;
  logic [LO_W-1:0]  prod_lo;
  logic [HP_W-1:0]  prod_hi;
  logic [P_W-1:0]   p_sum;
  logic [IDX_W-1:0] cnt, tgt, sel, inc_idx;
  logic [OCC_W-1:0] cap, inc_val, read_val;
  logic [SQ_W-1:0]  sq_new, sq_old;
  logic [SUM_W-1:0] inc_term, dec_term;
  logic             in_rng, scan_last, dec_en, inc_en;
  logic [OUTC_W-1:0] hop_out;
  hop_vals_t        hv;
  cell_ctl_t        ctl;
  logic [OCC_W-1:0] occ_row [NUM_BINS];

  assign busy      = (state != S_IDLE);
  assign tgt       = IDX_W'(req.bin);
  assign in_rng    = (int'(req.bin) < NUM_BINS);
  assign scan_last = (cnt == IDX_LAST);
  assign p_sum     = P_W'({prod_hi, RATE_W'(0)}) + P_W'(prod_lo);
  assign read_val  = !in_rng ? '0 : ((cnt == tgt) ? occ_row[0] : cap);
  assign total_wr  = in_rng ? (total + SUM_W'(sq_new) - SUM_W'(sq_old)) : total;

  // open-boundary hop rules with reservoir end bins
  always_comb begin
    dec_en  = 1'b0;
    inc_en  = 1'b0;
    inc_idx = sel;
    hop_out = OUT_HOP;
    if ((sel == IDX_ONE) && !req.rand_dir) begin
      dec_en  = 1'b1;
      hop_out = OUT_EXIT_L;
    end else if ((sel == IDX_LAST2) && req.rand_dir) begin
      dec_en  = 1'b1;
      hop_out = OUT_EXIT_R;
    end else if ((sel == '0) && !req.rand_dir) begin
      hop_out = OUT_REJECT;
    end else if (sel == '0) begin
      inc_en  = 1'b1;
      inc_idx = IDX_ONE;
      hop_out = OUT_INJ_L;
    end else if ((sel == IDX_LAST) && req.rand_dir) begin
      hop_out = OUT_REJECT;
    end else if (sel == IDX_LAST) begin
      inc_en  = 1'b1;
      inc_idx = IDX_LAST2;
      hop_out = OUT_INJ_R;
    end else begin
      dec_en  = 1'b1;
      inc_en  = 1'b1;
      inc_idx = req.rand_dir ? (sel + IDX_ONE) : (sel - IDX_ONE);
    end
  end

  assign inc_val   = req.rand_dir ? hv.right : hv.left;
  assign inc_term  = (inc_en && (inc_val != OCC_MAX)) ? SUM_W'({inc_val, 1'b1}) : '0;
  assign dec_term  = (dec_en && (hv.cur != '0)) ?
                     SUM_W'({hv.cur - OCC_W'(1), 1'b1}) : '0;
  assign total_hop = total + inc_term - dec_term;

  assign ctl.shift    = (state == S_SCAN);
  assign ctl.load     = (state == S_WRITE) && in_rng;
  assign ctl.dec      = (state == S_HOP) && dec_en;
  assign ctl.inc      = (state == S_HOP) && inc_en;
  assign ctl.load_val = req.value;

  for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
    zrkmc_cell #(
      .IDX_W (IDX_W),
      .POS   (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .load_idx (tgt),
      .dec_idx  (sel),
      .inc_idx  (inc_idx),
      .nbr      (occ_row[(k + 1) % NUM_BINS]),
      .occ      (occ_row[k])
    );
  end

  zrkmc_scan #(
    .NUM_BINS (NUM_BINS),
    .IDX_W    (IDX_W),
    .SUM_W    (SUM_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (state == S_PROD),
    .tap_valid ((state == S_SCAN) && (req.cmd == CMD_EVENT)),
    .tap_val   (occ_row[0]),
    .tap_idx   (cnt),
    .thresh    (thresh),
    .rem       (rem),
    .sel       (sel),
    .vals      (hv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
      total <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req <= item;
            unique case (item.cmd) inside
              CMD_WRITE, CMD_READ: begin
                state <= S_SCAN;
              end
              CMD_EVENT: begin
                if (total == '0) begin
                  done   <= 1'b1;
                  result <= '{total_rate: TOTAL_W'(total), chosen_bin: '0,
                              went_right: 1'b0, outcome: OUT_ZERO, read_value: '0};
                end else begin
                  state <= S_MUL;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '{total_rate: TOTAL_W'(total), chosen_bin: '0,
                            went_right: 1'b0, outcome: OUT_NONE, read_value: '0};
              end
            endcase
          end
        end
        S_MUL: begin
          prod_lo <= LO_W'(total[RATE_W-1:0]) * LO_W'(req.rand_rate);
          prod_hi <= HP_W'(total[SUM_W-1:RATE_W]) * HP_W'(req.rand_rate);
          state   <= S_PROD;
        end
        S_PROD: begin
          thresh <= p_sum[P_W-1:RATE_W];
          rem    <= |p_sum[RATE_W-1:0];
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (cnt == tgt) begin
            cap <= occ_row[0];
          end
          if (scan_last) begin
            cnt <= '0;
            unique case (req.cmd) inside
              CMD_READ: begin
                done   <= 1'b1;
                result <= '{total_rate: TOTAL_W'(total), chosen_bin: '0,
                            went_right: 1'b0, outcome: OUT_NONE, read_value: read_val};
                state  <= S_IDLE;
              end
              CMD_WRITE: begin
                state <= S_SQ;
              end
              default: begin
                state <= S_FILL;
              end
            endcase
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_FILL: begin
          state <= S_FLUSH;
        end
        S_FLUSH: begin
          state <= S_HOP;
        end
        S_HOP: begin
          total  <= total_hop;
          done   <= 1'b1;
          result <= '{total_rate: TOTAL_W'(total_hop), chosen_bin: BIN_W'(sel),
                      went_right: req.rand_dir, outcome: hop_out, read_value: '0};
          state  <= S_IDLE;
        end
        S_SQ: begin
          sq_new <= SQ_W'(req.value) * SQ_W'(req.value);
          sq_old <= SQ_W'(cap) * SQ_W'(cap);
          state  <= S_WRITE;
        end
        S_WRITE: begin
          total  <= total_wr;
          done   <= 1'b1;
          result <= '{total_rate: TOTAL_W'(total_wr), chosen_bin: '0,
                      went_right: 1'b0, outcome: OUT_NONE, read_value: '0};
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a transaction is in flight");

  a_zero_total: assert property (@(posedge clk) disable iff (rst)
    (done && (result.outcome == OUT_ZERO)) |-> (result.total_rate == '0))
    else $error("zero-rate outcome with nonzero total");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without an accepted transaction");

  a_cnt_home: assert property (@(posedge clk) disable iff (rst)
    (state != S_SCAN) |-> (cnt == '0))
    else $error("ring lap counter not home outside a scan");

  a_hop_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOP) |-> (total != '0))
    else $error("hop applied with zero total rate");

endmodule
